FILE: sv/tcc_pkg.sv
// Shared types and constants for the text console engine.
// Used by tcc_ctrl, tcc_datapath and the text_console_cursor_scroll top level.
package tcc_pkg;

  localparam int CELL_COUNT = 2048;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int PTR_W      = ADDR_W + 1;
  // wide enough for rows*columns, cursor address and walk source address
  localparam int WIDE_W     = 15;

  localparam logic [7:0] MAX_COLS      = 8'd128;
  localparam logic [6:0] MAX_ROWS      = 7'd64;
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [6:0] RESET_ROWS    = 7'd25;
  localparam logic [7:0] RESET_ATTR    = 8'h0F;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] TAB_STEP   = 8'd8;
  localparam logic [7:0] TAB_MASK   = 8'(8 - 1);

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_ATTR    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    WALK_BOOT,
    WALK_CLEAR,
    WALK_SCROLL
  } walk_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_BOOT,
    ST_IDLE,
    ST_PUT,
    ST_CLEAR,
    ST_READ,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       put;
    logic       home;
    logic       read_issue;
    logic       walk_start;
    walk_mode_t walk_mode;
    logic       walk_step;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scroll_req;
    logic walk_done;
  } dp_status_t;

endpackage

FILE: sv/tcc_ctrl.sv
// Sequencer for the text console engine: item dispatch, cell store walks,
// result handoff. Depends on tcc_pkg.
module tcc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           operation,
  input  logic                 out_stall,
  input  tcc_pkg::dp_status_t  status,
  output tcc_pkg::dp_cmd_t     cmd,
  output logic                 in_stall,
  output logic                 out_valid
);

  tcc_pkg::state_t state, state_next;
  logic            accept;
  logic            out_free;

  assign in_stall = (state != tcc_pkg::ST_IDLE);
  assign accept   = in_valid && (state == tcc_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcc_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tcc_pkg::ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcc_pkg::ST_INIT: state_next = tcc_pkg::ST_BOOT;
      tcc_pkg::ST_BOOT: begin
        if (status.walk_done) state_next = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (tcc_pkg::op_t'(operation))
            tcc_pkg::OP_PUT:   state_next = tcc_pkg::ST_PUT;
            tcc_pkg::OP_CLEAR: state_next = tcc_pkg::ST_CLEAR;
            tcc_pkg::OP_READ:  state_next = tcc_pkg::ST_READ;
            default:           state_next = tcc_pkg::ST_FIN;
          endcase
        end
      end
      tcc_pkg::ST_PUT: begin
        state_next = status.scroll_req ? tcc_pkg::ST_WALK : tcc_pkg::ST_FIN;
      end
      tcc_pkg::ST_CLEAR: state_next = tcc_pkg::ST_WALK;
      tcc_pkg::ST_READ:  state_next = tcc_pkg::ST_FIN;
      tcc_pkg::ST_WALK: begin
        if (status.walk_done) state_next = tcc_pkg::ST_FIN;
      end
      tcc_pkg::ST_FIN: begin
        if (out_free) state_next = tcc_pkg::ST_IDLE;
      end
      default: state_next = tcc_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.walk_mode  = tcc_pkg::WALK_BOOT;
    cmd.accept     = accept;
    unique case (state)
      tcc_pkg::ST_INIT: begin
        cmd.walk_start = 1'b1;
        cmd.walk_mode  = tcc_pkg::WALK_BOOT;
      end
      tcc_pkg::ST_BOOT: cmd.walk_step = 1'b1;
      tcc_pkg::ST_IDLE: ;
      tcc_pkg::ST_PUT: begin
        cmd.put        = 1'b1;
        cmd.walk_start = status.scroll_req;
        cmd.walk_mode  = tcc_pkg::WALK_SCROLL;
      end
      tcc_pkg::ST_CLEAR: begin
        cmd.home       = 1'b1;
        cmd.walk_start = 1'b1;
        cmd.walk_mode  = tcc_pkg::WALK_CLEAR;
      end
      tcc_pkg::ST_READ: cmd.read_issue = 1'b1;
      tcc_pkg::ST_WALK: cmd.walk_step  = 1'b1;
      tcc_pkg::ST_FIN:  cmd.load_out   = out_free;
      default: ;
    endcase
  end

endmodule

FILE: sv/tcc_datapath.sv
// Datapath of the text console engine: config registers, cursor, cell store,
// walk pointer for scroll/clear, result registers. Depends on tcc_pkg.
module tcc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tcc_pkg::dp_cmd_t    cmd,
  output tcc_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [1:0]          operation,
  input  logic [7:0]          char_code,
  input  logic [10:0]         cell_index,
  output logic [10:0]         cursor_pos,
  output logic [5:0]          cursor_row,
  output logic [6:0]          cursor_col,
  output logic [15:0]         read_data,
  output logic                scrolled
);

  localparam int AW = tcc_pkg::ADDR_W;
  localparam int PW = tcc_pkg::PTR_W;
  localparam int WW = tcc_pkg::WIDE_W;

  logic [7:0]  reg_columns;
  logic [6:0]  reg_rows;
  logic [7:0]  reg_attr;
  logic [7:0]  w_eff;
  logic [6:0]  h_eff;
  logic [6:0]  h_last;

  logic [1:0]  op_q;
  logic [7:0]  code_q;
  logic [10:0] idx_q;
  logic [6:0]  cur_col;
  logic [5:0]  cur_line;
  logic        scrolled_q;

  logic [7:0]  col_t;
  logic [6:0]  line_t;
  logic        put_wr;
  logic [13:0] cur_prod;
  logic [WW-1:0] cur_addr;
  logic        cur_in;

  logic [WW-1:0] geo_area;
  logic [WW-1:0] geo_copy;
  logic [PW-1:0] area_capped;

  logic [PW-1:0] ptr;
  logic [PW-1:0] walk_end;
  logic [WW-1:0] copy_lim;
  logic [15:0]   fill;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic          wr_mem;
  logic          wr_zero;
  logic [WW-1:0] src_wide;
  logic          src_in;
  logic          in_copy;
  logic          stage;

  logic [15:0]   cells [tcc_pkg::CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic [WW-1:0] idx_wide;
  logic          idx_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_columns <= tcc_pkg::RESET_COLUMNS;
      reg_rows    <= tcc_pkg::RESET_ROWS;
      reg_attr    <= tcc_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcc_pkg::REG_COLUMNS: reg_columns <= cfg_data;
        tcc_pkg::REG_ROWS:    reg_rows    <= cfg_data[6:0];
        tcc_pkg::REG_ATTR:    reg_attr    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (reg_columns == 8'd0)            w_eff = 8'd1;
    else if (reg_columns > tcc_pkg::MAX_COLS)    w_eff = tcc_pkg::MAX_COLS;
    else                                         w_eff = reg_columns;
    priority if (reg_rows == 7'd0)               h_eff = 7'd1;
    else if (reg_rows > tcc_pkg::MAX_ROWS)       h_eff = tcc_pkg::MAX_ROWS;
    else                                         h_eff = reg_rows;
  end
  assign h_last = h_eff - 7'd1;

  // geometry products, settled well before any walk starts
  always_ff @(posedge clk) begin
    geo_area <= {8'd0, h_eff} * {7'd0, w_eff};
    geo_copy <= {8'd0, h_last} * {7'd0, w_eff};
  end
  assign area_capped = (geo_area < WW'(tcc_pkg::CELL_COUNT)) ? geo_area[PW-1:0]
                                                            : PW'(tcc_pkg::CELL_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= operation;
      code_q <= char_code;
      idx_q  <= cell_index;
    end
  end

  // put-character cursor step
  always_comb begin
    col_t  = {1'b0, cur_col};
    line_t = {1'b0, cur_line};
    put_wr = 1'b0;
    unique case (code_q)
      tcc_pkg::CH_BS: begin
        if (cur_col != 7'd0) col_t = {1'b0, cur_col} - 8'd1;
      end
      tcc_pkg::CH_TAB: col_t = ({1'b0, cur_col} + tcc_pkg::TAB_STEP) & ~tcc_pkg::TAB_MASK;
      tcc_pkg::CH_CR:  col_t = 8'd0;
      tcc_pkg::CH_LF: begin
        line_t = line_t + 7'd1;
        col_t  = 8'd0;
      end
      default: begin
        if (code_q >= tcc_pkg::BLANK_CHAR && code_q <= tcc_pkg::CHAR_LAST) begin
          put_wr = 1'b1;
          col_t  = col_t + 8'd1;
        end
      end
    endcase
    if (col_t >= w_eff) begin
      col_t  = 8'd0;
      line_t = line_t + 7'd1;
    end
  end

  assign status.scroll_req = (line_t >= h_eff);

  // linear cursor: write address during put, reported value at finish
  assign cur_prod = {8'd0, cur_line} * {6'd0, w_eff};
  assign cur_addr = WW'(cur_prod) + WW'(cur_col);
  assign cur_in   = cur_addr < WW'(tcc_pkg::CELL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= 7'd0;
      cur_line   <= 6'd0;
      scrolled_q <= 1'b0;
    end else begin
      if (cmd.home) begin
        cur_col  <= 7'd0;
        cur_line <= 6'd0;
      end else if (cmd.put) begin
        cur_col  <= col_t[6:0];
        cur_line <= status.scroll_req ? h_last[5:0] : line_t[5:0];
      end
      if (cmd.accept) begin
        scrolled_q <= 1'b0;
      end else if (cmd.put && status.scroll_req) begin
        scrolled_q <= 1'b1;
      end
    end
  end

  // store walk: stage one cell per cycle, write it the cycle after
  assign src_wide = WW'(ptr) + WW'(w_eff);
  assign src_in   = src_wide < WW'(tcc_pkg::CELL_COUNT);
  assign in_copy  = WW'(ptr) < copy_lim;
  assign stage    = ptr < walk_end;
  assign status.walk_done = (ptr >= walk_end) && !wr_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      wr_pend <= 1'b0;
    end else if (cmd.walk_start) begin
      ptr     <= '0;
      wr_pend <= 1'b0;
    end else if (cmd.walk_step) begin
      wr_pend <= stage;
      if (stage) ptr <= ptr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      unique case (cmd.walk_mode)
        tcc_pkg::WALK_BOOT: begin
          walk_end <= PW'(tcc_pkg::CELL_COUNT);
          copy_lim <= '0;
          fill     <= {tcc_pkg::RESET_ATTR, tcc_pkg::BLANK_CHAR};
        end
        tcc_pkg::WALK_CLEAR: begin
          walk_end <= area_capped;
          copy_lim <= '0;
          fill     <= {reg_attr, tcc_pkg::BLANK_CHAR};
        end
        tcc_pkg::WALK_SCROLL: begin
          walk_end <= area_capped;
          copy_lim <= geo_copy;
          fill     <= {reg_attr, tcc_pkg::BLANK_CHAR};
        end
        default: begin
          walk_end <= '0;
          copy_lim <= '0;
          fill     <= {reg_attr, tcc_pkg::BLANK_CHAR};
        end
      endcase
    end
    if (cmd.walk_step) begin
      wr_addr <= ptr[AW-1:0];
      wr_mem  <= in_copy && src_in;
      wr_zero <= in_copy && !src_in;
    end
  end

  // cell store
  assign idx_wide = WW'(idx_q);
  assign idx_in   = idx_wide < WW'(tcc_pkg::CELL_COUNT);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = fill;
    if (wr_pend) begin
      mem_we = 1'b1;
      if (wr_mem)       mem_wdata = rd_data;
      else if (wr_zero) mem_wdata = 16'd0;
    end else if (cmd.put && put_wr && cur_in) begin
      mem_we    = 1'b1;
      mem_waddr = cur_addr[AW-1:0];
      mem_wdata = {reg_attr, code_q};
    end
  end

  assign rd_en   = cmd.read_issue || (cmd.walk_step && stage && in_copy && src_in);
  assign rd_addr = cmd.read_issue ? idx_wide[AW-1:0] : src_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= cells[rd_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_pos <= cur_addr[10:0];
      cursor_row <= cur_line;
      cursor_col <= cur_col;
      read_data  <= (op_q == tcc_pkg::OP_READ && idx_in) ? rd_data : 16'd0;
      scrolled   <= scrolled_q;
    end
  end

endmodule

FILE: sv/text_console_cursor_scroll.sv
// Text console engine top level: sequencer plus datapath with cell store.
// Depends on tcc_pkg, tcc_ctrl and tcc_datapath.
//
// Takes one item at a time. Put-character and read-cell go from the accepting
// edge through a store access state and a result load state to a result in
// the output register; an unused operation code goes straight to the result
// load. The next item is accepted in the cycle after the result load. A put
// that scrolls and a clear add a walk over min(columns*rows, 2048) cells: the
// walk moves one cell per cycle through the store's single write port, with
// the read of the next source cell overlapped, and then writes the last cell
// and finishes. After reset the store is swept to blank cells; in_stall stays
// high from reset until the sweep is done. Config writes are taken at any time
// (cfg_ready is tied high) but are meant for an idle block only.
// A finished result waits in the output register while the next item is
// accepted.
module text_console_cursor_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] cursor_pos,
  output logic [5:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [15:0] read_data,
  output logic        scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tcc_pkg::dp_cmd_t    cmd;
  tcc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  tcc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .char_code  (char_code),
    .cell_index (cell_index),
    .cursor_pos (cursor_pos),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .read_data  (read_data),
    .scrolled   (scrolled)
  );

endmodule
